/* rtl/fraction_reducer_core_defines.svh */
// Assertion macros shared by the fraction reducer RTL.
`ifndef FRACTION_REDUCER_CORE_DEFINES_SVH
`define FRACTION_REDUCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fraction reducer check failed");

// The consequent must hold in the cycle after the antecedent.
`define FR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fraction reducer check failed");

`endif

/* rtl/fr_pkg.sv */
`default_nettype none

package fr_pkg;

    // Default width of every numerator and denominator field.
    localparam int unsigned VALUE_WIDTH_DEF = 31;

    // Sequencer states of the reducer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FINISH
    } fr_state_t;

endpackage

`default_nettype wire

/* rtl/fraction_reducer_core.sv */
// A request with a zero part goes straight to the finish state once accepted; any other
// request passes through the binary GCD search and then the two restoring divisions. The
// block takes no new request before it is through with the last one, as the single shared
// subtractor carries both the GCD search and the two restoring divisions; ready is high only
// when idle. Reset: rst_n is asynchronous and active low; it clears the sequencer and the
// result valid.
`default_nettype none

module fraction_reducer_core
    import fr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [VALUE_WIDTH-1:0] numerator,
    input  wire logic [VALUE_WIDTH-1:0] denominator,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [VALUE_WIDTH-1:0]      reduced_numerator,
    output logic [VALUE_WIDTH-1:0]      reduced_denominator
);

    `include "fraction_reducer_core_defines.svh"

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    // Sequencer state.
    fr_state_t state_reg, state_next;

    // Working operands of the GCD search. After the search b_reg holds the odd part
    // of the greatest common divisor, which is then the divisor of both divisions.
    logic [VALUE_WIDTH-1:0] a_reg;
    logic [VALUE_WIDTH-1:0] b_reg;

    // Numerator and denominator, shifted right together with the common powers of two.
    // During a division the quotient bits shift into the low end of the dividend.
    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] d_reg;

    // Partial remainder and bit counter of the restoring division.
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // Result register, so that a new request may start while a result waits.
    logic                   res_valid_reg;
    logic [VALUE_WIDTH-1:0] res_num_reg;
    logic [VALUE_WIDTH-1:0] res_den_reg;

    // The shared subtractor. Its top bit is the borrow.
    logic [VALUE_WIDTH:0]   sub_a;
    logic [VALUE_WIDTH:0]   sub_b;
    logic [VALUE_WIDTH+1:0] diff;
    logic                   borrow;

    // Control decoded from the state.
    logic                   accept;
    logic                   zero_case;
    logic                   gcd_done;
    logic                   div_msb;
    logic                   load_result;

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[VALUE_WIDTH+1];

    assign item_ready          = (state_reg == ST_IDLE);
    assign result_valid        = res_valid_reg;
    assign reduced_numerator   = res_num_reg;
    assign reduced_denominator = res_den_reg;

    // Control and operand selection.
    always_comb
    begin
        accept      = item_valid && item_ready;
        zero_case   = (numerator == '0) || (denominator == '0);
        gcd_done    = (a_reg == '0);
        div_msb     = (state_reg == ST_DIVD) ? d_reg[VALUE_WIDTH-1] : n_reg[VALUE_WIDTH-1];
        load_result = (state_reg == ST_FINISH) && (!res_valid_reg || result_ready);
        if (state_reg == ST_GCD)
        begin
            sub_a = {1'b0, a_reg};
        end
        else
        begin
            sub_a = {rem_reg, div_msb};
        end
        sub_b = {1'b0, b_reg};
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = zero_case ? ST_FINISH : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_reg <= numerator;
                    b_reg <= denominator;
                    n_reg <= numerator;
                    d_reg <= denominator;
                end
            end
            ST_GCD:
            begin
                // Stein's algorithm. Common factors of two leave all four registers
                // together; once b_reg is odd, it stays odd until the search ends.
                if (gcd_done)
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    n_reg <= n_reg >> 1;
                    d_reg <= d_reg >> 1;
                end
                else if (!a_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_reg <= b_reg >> 1;
                end
                else if (borrow)
                begin
                    a_reg <= b_reg;
                    b_reg <= a_reg;
                end
                else
                begin
                    a_reg <= diff[VALUE_WIDTH-1:0];
                end
            end
            ST_DIVN:
            begin
                n_reg <= {n_reg[VALUE_WIDTH-2:0], ~borrow};
                if (cnt_reg == CNT_LAST)
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    rem_reg <= borrow ? sub_a[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_DIVD:
            begin
                rem_reg <= borrow ? sub_a[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
                d_reg   <= {d_reg[VALUE_WIDTH-2:0], ~borrow};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    res_num_reg <= n_reg;
                    res_den_reg <= d_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The divisor is never zero while dividing.
    `FR_ASSERT_SAME(a_divisor_nonzero,
        (state_reg == ST_DIVN) || (state_reg == ST_DIVD), b_reg != '0)
    // The partial remainder always stays below the divisor.
    `FR_ASSERT_SAME(a_rem_below_divisor,
        (state_reg == ST_DIVN) || (state_reg == ST_DIVD), rem_reg < b_reg)
    // A finished result is handed to the result register and the sequencer frees.
    `FR_ASSERT_NEXT(a_finish_loads,
        load_result, res_valid_reg && (state_reg == ST_IDLE))
    // An accepted request always leaves the idle state.
    `FR_ASSERT_NEXT(a_accept_starts,
        accept, state_reg != ST_IDLE)

endmodule

`default_nettype wire

/* tb/sv/fraction_reducer_checker.sv */
module fraction_reducer_checker
    import fr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  logic [VALUE_WIDTH-1:0] numerator,
    input  logic [VALUE_WIDTH-1:0] denominator,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  logic [VALUE_WIDTH-1:0] reduced_numerator,
    input  logic [VALUE_WIDTH-1:0] reduced_denominator,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] num;
        logic [VALUE_WIDTH-1:0] den;
    } fraction_t;

    fraction_t lowest_terms_q[$];
    int        mismatches   = 0;
    int        results_seen = 0;

    // Both parts are divided by their greatest common divisor, found by Euclid's
    // method. A fraction with a zero part is left exactly as it came in.
    function automatic fraction_t lowest_terms(logic [VALUE_WIDTH-1:0] n,
                                               logic [VALUE_WIDTH-1:0] d);
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        fraction_t       f;
        f.num = n;
        f.den = d;
        if (n != '0 && d != '0)
        begin
            a = n;
            b = d;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            f.num = VALUE_WIDTH'(longint'(n) / a);
            f.den = VALUE_WIDTH'(longint'(d) / a);
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what,
                 got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n)
        begin
            // A result leaving now belongs to an older request than any one
            // entering at the same edge, so the result side is handled first.
            if (result_valid && result_ready)
            begin
                if (lowest_terms_q.size() == 0)
                begin
                    report_mismatch("reduced_numerator with no request outstanding",
                                    reduced_numerator, 0);
                end
                else
                begin
                    want = lowest_terms_q.pop_front();
                    if (reduced_numerator !== want.num)
                        report_mismatch("reduced_numerator", reduced_numerator, want.num);
                    if (reduced_denominator !== want.den)
                        report_mismatch("reduced_denominator", reduced_denominator, want.den);
                end
                results_seen++;
            end
            if (item_valid && item_ready)
                lowest_terms_q.push_back(lowest_terms(numerator, denominator));
        end
        fail_count <= mismatches;
        pending    <= lowest_terms_q.size();
    end

endmodule

/* tb/sv/fraction_reducer_core_tb.sv */
// Top level of the fraction reducer testbench. It makes the requests, works the
// result side, and gives the verdict; the checker beside the block predicts each
// result and counts mismatches.
module fraction_reducer_core_tb
    import fr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned W = VALUE_WIDTH_DEF;
    localparam longint unsigned MAXV = (64'd1 << W) - 1;

    // Number of random requests after the directed ones.
    localparam int RANDOM_REQUESTS = 1930;

    // The limit on cycles without any handshake is taken well above both the
    // time a correct block needs to give a result and the longest receiver
    // hold-off.
    localparam int STALL_LIMIT = 4000;

    // Cycles the receiver holds off once to make the block stall its input.
    localparam int LONG_HOLD = 450;

    // Cycles waited at the end for any stray result.
    localparam int DRAIN_CYCLES = 300;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    logic [W-1:0] numerator;
    logic [W-1:0] denominator;
    logic         result_valid;
    logic         result_ready;
    logic [W-1:0] reduced_numerator;
    logic [W-1:0] reduced_denominator;
    int           fail_count;
    int           pending;

    int requests_sent = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;

    fraction_reducer_core u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .numerator           (numerator),
        .denominator         (denominator),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator)
    );

    fraction_reducer_checker #(.VALUE_WIDTH(W)) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .numerator           (numerator),
        .denominator         (denominator),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog ends the run once nothing has moved on either channel for
    // too long, which only a hung block can cause.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. The sender works
    // in bursts: after a burst ends it drops valid for a random gap. Every third
    // stretch of 150 requests runs with no gaps at all.
    task automatic send_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
        item_valid  <= 1'b1;
        numerator   <= n;
        denominator <= d;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        requests_sent++;
        if ((requests_sent / 150) % 3 == 1)
            burst_left = 1;
        if (burst_left <= 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    // Draws a random fraction. About 35 percent of requests share a built-in
    // common factor, giving the division real work; the rest cover whole-range
    // values, zero parts, small values, powers of two, multiples and values near
    // the top of the range.
    task automatic random_fraction(output logic [W-1:0] n, output logic [W-1:0] d);
        longint unsigned g;
        longint unsigned lim;
        int              kind;
        int              bits;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            bits = $urandom_range(1, 20);
            g    = $urandom_range(1, (32'd1 << bits) - 1);
            lim  = MAXV / g;
            n    = W'(g * $urandom_range(1, 32'(lim)));
            d    = W'(g * $urandom_range(1, 32'(lim)));
        end
        else if (kind < 55)
        begin
            n = W'($urandom);
            d = W'($urandom);
        end
        else if (kind < 65)
        begin
            n = W'($urandom);
            d = W'($urandom);
            case ($urandom_range(0, 2))
                0: n = '0;
                1: d = '0;
                default:
                begin
                    n = '0;
                    d = '0;
                end
            endcase
        end
        else if (kind < 75)
        begin
            n = W'($urandom_range(1, 1000));
            d = W'($urandom_range(1, 1000));
        end
        else if (kind < 85)
        begin
            n = W'($urandom_range(1, 255)) << $urandom_range(0, W - 1);
            d = W'($urandom_range(1, 255)) << $urandom_range(0, W - 1);
        end
        else if (kind < 93)
        begin
            d = W'($urandom_range(1, 1 << 16));
            n = W'(longint'(d) * $urandom_range(1, 1 << 14));
            if ($urandom_range(0, 1))
            begin
                g = n;
                n = d;
                d = W'(g);
            end
        end
        else
        begin
            n = W'(MAXV - $urandom_range(0, 1000));
            d = $urandom_range(0, 1) ? n - 1'b1 : W'(MAXV - $urandom_range(0, 1000));
        end
    endtask

    // The result side stalls in modes that change at random intervals:
    // always ready, ready at random, or ready only now and then. Once, after a
    // good number of results, it holds off for a long stretch so that the block
    // is left with a finished result and must refuse new requests meanwhile.
    initial
    begin
        int   mode;
        int   run_left;
        int   results_taken;
        bit   held;
        logic take;
        mode          = 0;
        run_left      = 0;
        results_taken = 0;
        held          = 1'b0;
        result_ready  <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (run_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                run_left = $urandom_range(50, 300);
            end
            run_left--;
            case (mode)
                0:       take = 1'b1;
                1:       take = $urandom_range(0, 1);
                default: take = ($urandom_range(0, 5) == 0);
            endcase
            result_ready <= take;
            @(posedge clk);
            if (result_valid && result_ready)
                results_taken++;
            if (!held && results_taken >= 600)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [W-1:0] n;
        logic [W-1:0] d;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        numerator   <= '0;
        denominator <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: zero parts, both extremes, equal parts, fractions
        // already in lowest terms, large common factors, and a consecutive
        // Fibonacci pair in both orders.
        send_fraction('0, '0);
        send_fraction('0, W'(MAXV));
        send_fraction(W'(MAXV), '0);
        send_fraction('0, W'(5));
        send_fraction(W'(5), '0);
        send_fraction(W'(1), W'(1));
        send_fraction(W'(MAXV), W'(MAXV));
        send_fraction(W'(1), W'(MAXV));
        send_fraction(W'(MAXV), W'(1));
        send_fraction(W'(MAXV), W'(MAXV - 1));
        send_fraction(W'(7), W'(7));
        send_fraction(W'(12), W'(18));
        send_fraction(W'(2147483646), W'(1431655764));
        send_fraction(31'h4000_0000, 31'h2000_0000);
        send_fraction(31'h4000_0000, 31'h4000_0000);
        send_fraction(31'h4000_0000, W'(3));
        send_fraction(31'h2AAA_AAAA, 31'h5555_5555);
        send_fraction(W'(1836311903), W'(1134903170));
        send_fraction(W'(1134903170), W'(1836311903));
        send_fraction(W'(1000000000), W'(2000000000));

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Once mid-run the sender stops until every result is home, so the
            // block is seen to go fully idle and restart cleanly.
            if (i == 1000)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            random_fraction(n, d);
            send_fraction(n, d);
        end
        item_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* fraction_reducer_core.f */
+incdir+rtl
rtl/fr_pkg.sv
rtl/fraction_reducer_core.sv
tb/sv/fraction_reducer_checker.sv
tb/sv/fraction_reducer_core_tb.sv
